@@ rtl/sctq_pkg.sv @@
// Package for the sorted countdown timer queue.
// Holds the transaction payload types, the cell row types and the sequencer states.
// No dependencies.
package sctq_pkg;

  localparam int unsigned NumTimersDef = 32;
  localparam int unsigned MaxResults   = 32;
  localparam int unsigned IdW          = 5;
  localparam int unsigned CdW          = 32;
  localparam int unsigned MsW          = 31;
  localparam int unsigned EwW          = 16;
  localparam logic [EwW-1:0] EmptyWaitRst = 16'd1000;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_STOP    = 2'd1,
    OP_TICK    = 2'd2,
    OP_SERVICE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TICK,
    CELL_REMOVE,
    CELL_INSERT,
    CELL_REQUEUE
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INSERT,
    ST_REPORT,
    ST_SERVICE
  } seq_state_e;

  typedef struct packed {
    logic [1:0]     opcode;
    logic [IdW-1:0] timer_id;
    logic [MsW-1:0] interval_ms;
    logic [MsW-1:0] elapsed_ms;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0]        fired_id;
    logic                  fired;
    logic signed [CdW-1:0] time_until_first;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic                  valid;
    logic [IdW-1:0]        owner;
    logic signed [CdW-1:0] cd;
  } entry_t;

  typedef struct packed {
    cell_op_e              op;
    logic                  strict;
    logic signed [CdW-1:0] key;
    logic [IdW-1:0]        id;
    logic [MsW-1:0]        elapsed;
  } cell_cmd_t;

  typedef struct packed {
    logic ahead;
    logic past;
    logic lt;
    logic same;
    logic up;
  } cell_flag_t;

endpackage

@@ rtl/sctq_cell.sv @@
// One slot of the sorted countdown list: owner, countdown and valid bit.
// Shifts with its neighbours on insert, remove and requeue. Uses sctq_pkg.
module sctq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sctq_pkg::cell_cmd_t cmd_i,
  input  sctq_pkg::entry_t    left_i,
  input  sctq_pkg::entry_t    right_i,
  input  sctq_pkg::cell_flag_t left_flag_i,
  input  sctq_pkg::cell_flag_t right_flag_i,
  output sctq_pkg::entry_t    entry_o,
  output sctq_pkg::cell_flag_t flag_o
);
  import sctq_pkg::*;

  entry_t              entry_q, entry_d;
  entry_t              fresh;
  logic                lt, le, hit;
  logic signed [CdW:0] diff;
  logic signed [CdW-1:0] sat;

  assign lt  = entry_q.valid && (entry_q.cd < cmd_i.key);
  assign le  = entry_q.valid && (entry_q.cd <= cmd_i.key);
  assign hit = entry_q.valid && (entry_q.owner == cmd_i.id);

  assign flag_o.lt     = lt;
  assign flag_o.ahead  = cmd_i.strict ? lt : le;
  assign flag_o.past   = hit || left_flag_i.past;
  assign flag_o.same   = hit && (entry_q.cd == cmd_i.key);
  assign flag_o.up     = hit && (cmd_i.key > entry_q.cd);

  assign diff = {entry_q.cd[CdW-1], entry_q.cd} - $signed({2'b00, cmd_i.elapsed});
  assign sat  = (diff[CdW] != diff[CdW-1]) ? {1'b1, {(CdW-1){1'b0}}} : diff[CdW-1:0];

  assign fresh = '{valid: 1'b1, owner: cmd_i.id, cd: cmd_i.key};

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CELL_TICK: begin
        if (entry_q.valid) begin
          entry_d.cd = sat;
        end
      end
      CELL_REMOVE: begin
        if (flag_o.past) begin
          entry_d = right_i;
        end
      end
      CELL_INSERT: begin
        if (!flag_o.ahead) begin
          entry_d = left_flag_i.ahead ? fresh : left_i;
        end
      end
      CELL_REQUEUE: begin
        if (right_flag_i.lt) begin
          entry_d = right_i;
        end else if (lt) begin
          entry_d = fresh;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/sorted_countdown_timer_queue.sv @@
// Sorted countdown timer queue: a row of list cells driven by one sequencer.
// Depends on sctq_pkg and sctq_cell.
//
// Timers are kept as a row of NUM_TIMERS cells sorted by countdown, each cell
// holding one timer; the sequencer issues one row operation per cycle unless the
// output stalls. Every transaction is latched in the idle state, then executed: a
// start or stop directly, a restart that moves the timer by a remove then an insert,
// a tick by subtracting and then reporting the front, and a service by reloading and
// requeueing each fired timer in one row shift, the last report taking a step of its
// own. No transaction is taken while one is in progress; results wait in an output
// register and a stalled output holds the sequencer. The period table and the row
// valid bits clear at reset, so no clearing pass is needed.
module sorted_countdown_timer_queue #(
  parameter int unsigned NUM_TIMERS = sctq_pkg::NumTimersDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sctq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sctq_pkg::out_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import sctq_pkg::*;

  localparam int unsigned PerAw = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned ExtW  = ((PerAw > IdW) ? PerAw : IdW) + 1;
  localparam int unsigned KW    = $clog2(MaxResults + 1);

  seq_state_e     state_q, state_d;
  in_t            item_q;
  in_t            item_in;
  logic           strict_q, strict_d;
  logic [KW-1:0]  k_q, k_d;
  logic           pend_valid_q, pend_valid_d;
  logic [IdW-1:0] pend_id_q, pend_id_d;
  logic           out_valid_q, out_valid_d;
  out_t           out_q, out_d;
  logic [EwW-1:0] empty_wait_q;
  logic [MsW-1:0] period_q [NUM_TIMERS];

  cell_cmd_t      cmd;
  entry_t         ent [NUM_TIMERS];
  cell_flag_t     flg [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] same_v, up_v;

  logic [ExtW-1:0]  id_ext, own_ext;
  logic [PerAw-1:0] id_idx, own_idx, rd_idx;
  logic             id_ok, own_ok, out_free, expired, per_we;
  logic [MsW-1:0]   per_rd, per_wdata, req_per;
  logic [MsW-1:0]   iv_clamped;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-EwW){1'b0}}, empty_wait_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_wait_q <= EmptyWaitRst;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      empty_wait_q <= pwdata[EwW-1:0];
    end
  end

  // Cell row
  generate
    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      entry_t     l_ent, r_ent;
      cell_flag_t l_flg, r_flg;
      if (i == 0) begin : g_head
        assign l_ent = '0;
        assign l_flg = '{ahead: 1'b1, past: 1'b0, lt: 1'b0, same: 1'b0, up: 1'b0};
      end else begin : g_mid
        assign l_ent = ent[i-1];
        assign l_flg = flg[i-1];
      end
      if (i == NUM_TIMERS - 1) begin : g_tail
        assign r_ent = '0;
        assign r_flg = '0;
      end else begin : g_body
        assign r_ent = ent[i+1];
        assign r_flg = flg[i+1];
      end
      sctq_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .cmd_i        (cmd),
        .left_i       (l_ent),
        .right_i      (r_ent),
        .left_flag_i  (l_flg),
        .right_flag_i (r_flg),
        .entry_o      (ent[i]),
        .flag_o       (flg[i])
      );
      assign same_v[i] = flg[i].same;
      assign up_v[i]   = flg[i].up;
    end
  endgenerate

  // Period table
  assign id_ext  = ExtW'(item_q.timer_id);
  assign own_ext = ExtW'(ent[0].owner);
  assign id_ok   = id_ext < ExtW'(NUM_TIMERS);
  assign own_ok  = own_ext < ExtW'(NUM_TIMERS);
  assign id_idx  = id_ext[PerAw-1:0];
  assign own_idx = own_ext[PerAw-1:0];
  assign rd_idx  = (state_q == ST_SERVICE) ? own_idx : id_idx;
  assign per_rd  = period_q[rd_idx];
  assign req_per = (own_ok && (per_rd != '0)) ? per_rd : MsW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        period_q[i] <= '0;
      end
    end else if (per_we) begin
      period_q[id_idx] <= per_wdata;
    end
  end

  assign iv_clamped = (in_data_i.interval_ms == '0) ? MsW'(1) : in_data_i.interval_ms;
  assign item_in    = '{opcode: in_data_i.opcode, timer_id: in_data_i.timer_id,
                        interval_ms: iv_clamped, elapsed_ms: in_data_i.elapsed_ms};
  assign out_free   = !out_valid_q || !out_stall_i;
  assign expired    = ent[0].valid && (ent[0].cd <= 0) && (k_q < KW'(MaxResults));
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    strict_d     = strict_q;
    k_d          = k_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    per_we       = 1'b0;
    per_wdata    = item_q.interval_ms;
    cmd.op       = CELL_HOLD;
    cmd.strict   = 1'b0;
    cmd.key      = $signed({1'b0, item_q.interval_ms});
    cmd.id       = item_q.timer_id;
    cmd.elapsed  = item_q.elapsed_ms;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (opcode_e'(item_q.opcode))
          OP_START: begin
            if (id_ok) begin
              if (per_rd != '0) begin
                per_we = 1'b1;
                if (!(|same_v)) begin
                  cmd.op   = CELL_REMOVE;
                  strict_d = |up_v;
                  state_d  = ST_INSERT;
                end
              end else if (!ent[NUM_TIMERS-1].valid) begin
                per_we = 1'b1;
                cmd.op = CELL_INSERT;
              end
            end
          end
          OP_STOP: begin
            if (id_ok && (per_rd != '0)) begin
              per_we    = 1'b1;
              per_wdata = '0;
              cmd.op    = CELL_REMOVE;
            end
          end
          OP_TICK: begin
            cmd.op  = CELL_TICK;
            state_d = ST_REPORT;
          end
          OP_SERVICE: begin
            k_d     = '0;
            state_d = ST_SERVICE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_INSERT: begin
        cmd.op     = CELL_INSERT;
        cmd.strict = strict_q;
        state_d    = ST_IDLE;
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_d.fired_id             = '0;
          out_d.fired                = 1'b0;
          out_d.time_until_first     = ent[0].valid ? ent[0].cd
                                                    : $signed({{(CdW-EwW){1'b0}}, empty_wait_q});
          out_d.last                 = 1'b1;
          state_d                    = ST_IDLE;
        end
      end
      ST_SERVICE: begin
        if (expired) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = '{fired_id: pend_id_q, fired: 1'b1, time_until_first: '0,
                              last: 1'b0};
            end
            pend_valid_d = 1'b1;
            pend_id_d    = ent[0].owner;
            cmd.op       = CELL_REQUEUE;
            cmd.key      = $signed({1'b0, req_per});
            cmd.id       = ent[0].owner;
            k_d          = k_q + KW'(1);
          end
        end else if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = '{fired_id: pend_id_q, fired: 1'b1, time_until_first: '0,
                           last: 1'b1};
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      strict_q     <= 1'b0;
      k_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      strict_q     <= strict_d;
      k_q          <= k_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
    if ((state_q == ST_IDLE) && in_valid_i) begin
      item_q <= item_in;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
